@@ hw/rtl/csis_pkg.sv @@
// shared types and codes for the compacting integer set
// no dependencies; used by csis_ctrl and compacting_integer_set
`default_nettype none

package csis_pkg;

    localparam logic [1:0] REQ_ADD    = 2'd0;
    localparam logic [1:0] REQ_REMOVE = 2'd1;
    localparam logic [1:0] REQ_QUERY  = 2'd2;

    localparam int VALUE_W = 32;
    localparam int COUNT_W = 5;

    typedef struct packed {
        logic [1:0]                req_type;
        logic signed [VALUE_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic               was_present;
        logic               full_reject;
        logic [COUNT_W-1:0] element_count;
        logic               is_empty;
    } out_item_t;

    typedef struct packed {
        logic idle;
        logic done;
    } ctrl_status_t;

endpackage

`default_nettype wire

@@ hw/rtl/csis_ram.sv @@
// generic single write, single read port ram with registered read data
// no dependencies
`default_nettype none

module csis_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ hw/rtl/csis_ctrl.sv @@
// scan and compaction sequencer: one ram read and one compare per cycle
// depends on csis_pkg; drives one csis_ram instance
`default_nettype none

module csis_ctrl #(
    parameter int CAPACITY = 16
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire csis_pkg::in_item_t      item,
    input  wire logic                    res_free,
    output csis_pkg::ctrl_status_t       status,
    output csis_pkg::out_item_t          result,
    output logic                         ram_we,
    output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] ram_waddr,
    output logic [csis_pkg::VALUE_W-1:0] ram_wdata,
    output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] ram_raddr,
    input  wire logic [csis_pkg::VALUE_W-1:0] ram_rdata
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_SHIFT = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    state_t  state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic          pend_reg, pend_next;
    logic          found_reg, found_next;
    logic          reject_reg, reject_next;

    logic [1:0]                   req_reg;
    logic [csis_pkg::VALUE_W-1:0] value_reg;
    logic [AW-1:0]                pend_idx_reg, pend_idx_next;

    logic          match;
    logic [CW+csis_pkg::COUNT_W-1:0] count_ext;

    assign match = pend_reg && (ram_rdata == value_reg);

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        pend_next     = pend_reg;
        found_next    = found_reg;
        reject_next   = reject_reg;
        pend_idx_next = pend_idx_reg;
        ram_we        = 1'b0;
        ram_waddr     = pend_idx_reg - 1'b1;
        ram_wdata     = ram_rdata;
        ram_raddr     = idx_reg[AW-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next  = ST_SCAN;
                    idx_next    = '0;
                    pend_next   = 1'b0;
                    found_next  = 1'b0;
                    reject_next = 1'b0;
                end
            end

            ST_SCAN:
            begin
                if (match)
                begin
                    found_next = 1'b1;
                    pend_next  = 1'b0;
                    if (req_reg == csis_pkg::REQ_REMOVE)
                    begin
                        // entries after the hit move down one place
                        idx_next   = CW'(pend_idx_reg) + 1'b1;
                        state_next = ST_SHIFT;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
                else if (idx_reg < count_reg)
                begin
                    pend_next     = 1'b1;
                    pend_idx_next = idx_reg[AW-1:0];
                    idx_next      = idx_reg + 1'b1;
                end
                else
                begin
                    // every live entry compared without a hit
                    pend_next  = 1'b0;
                    state_next = ST_DONE;
                    if (req_reg == csis_pkg::REQ_ADD)
                    begin
                        if (count_reg < CW'(CAPACITY))
                        begin
                            ram_we     = 1'b1;
                            ram_waddr  = count_reg[AW-1:0];
                            ram_wdata  = value_reg;
                            count_next = count_reg + 1'b1;
                        end
                        else
                        begin
                            reject_next = 1'b1;
                        end
                    end
                end
            end

            ST_SHIFT:
            begin
                if (pend_reg)
                begin
                    ram_we = 1'b1;
                end
                if (idx_reg < count_reg)
                begin
                    pend_next     = 1'b1;
                    pend_idx_next = idx_reg[AW-1:0];
                    idx_next      = idx_reg + 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        count_next = count_reg - 1'b1;
                        state_next = ST_DONE;
                    end
                end
            end

            ST_DONE:
            begin
                if (res_free)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            idx_reg    <= '0;
            pend_reg   <= 1'b0;
            found_reg  <= 1'b0;
            reject_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            idx_reg    <= idx_next;
            pend_reg   <= pend_next;
            found_reg  <= found_next;
            reject_reg <= reject_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && (state_reg == ST_IDLE))
        begin
            req_reg   <= item.req_type;
            value_reg <= item.value;
        end
        pend_idx_reg <= pend_idx_next;
    end

    // count is reported modulo 32
    assign count_ext = (CW + csis_pkg::COUNT_W)'(count_reg);

    assign status.idle = (state_reg == ST_IDLE);
    assign status.done = (state_reg == ST_DONE);

    assign result.was_present   = found_reg;
    assign result.full_reject   = reject_reg;
    assign result.element_count = count_ext[csis_pkg::COUNT_W-1:0];
    assign result.is_empty      = (count_reg == '0);

endmodule

`default_nettype wire

@@ hw/rtl/compacting_integer_set.sv @@
// top level of the compacting integer set: request capture, response register
// depends on csis_pkg, csis_ctrl and csis_ram
//
//  channel  signals                      payload              direction
//  req      req_valid / req_ready        csis_pkg::in_item_t  in
//  rsp      rsp_valid / rsp_ready        csis_pkg::out_item_t out
//
// add or query compares the live entries in turn; remove also moves each later entry down,
// paced by the single read port of the entry ram (one entry compared or moved a cycle)
// req_ready is high only while the sequencer is idle; one request at a time
// a finished response waits in the response register; the sequencer holds in its
// done state until that register is free, so a stalled response delays the next request
// reset clears the element count; entry contents need no clearing
`default_nettype none

module compacting_integer_set #(
    parameter int CAPACITY = 16
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output logic                     req_ready,
    input  wire csis_pkg::in_item_t  req,
    output logic                     rsp_valid,
    input  wire logic                rsp_ready,
    output csis_pkg::out_item_t      rsp
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    csis_pkg::ctrl_status_t status;
    csis_pkg::out_item_t    result;
    logic                   res_free;
    logic                   start;

    logic                         ram_we;
    logic [AW-1:0]                ram_waddr;
    logic [AW-1:0]                ram_raddr;
    logic [csis_pkg::VALUE_W-1:0] ram_wdata;
    logic [csis_pkg::VALUE_W-1:0] ram_rdata;

    logic                rsp_valid_reg, rsp_valid_next;
    csis_pkg::out_item_t rsp_reg;

    assign req_ready = status.idle;
    assign start     = req_valid && status.idle;
    assign res_free  = !rsp_valid_reg || rsp_ready;

    csis_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .item      (req),
        .res_free  (res_free),
        .status    (status),
        .result    (result),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    csis_ram #(
        .WIDTH (csis_pkg::VALUE_W),
        .DEPTH (CAPACITY)
    ) u_entries (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // response transfer frees the register in the same cycle a new one loads
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (status.done && res_free)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (status.done && res_free)
        begin
            rsp_reg <= result;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire
